FILE: rtl/i2cms_pkg.sv
// Types, command codes and phase update helpers for the I2C master byte sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

	localparam int BYTE_BITS = 8;
	localparam int HP_W = 16;
	localparam int TMO_W = 8;
	localparam int CFG_W = 16;

	localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd5;
	localparam logic [TMO_W-1:0] ACK_TIMEOUT_RST = 8'd250;

	localparam logic [0:0] REG_HALF_PERIOD = 1'b0;
	localparam logic [0:0] REG_ACK_TIMEOUT = 1'b1;

	localparam logic [2:0] KIND_START = 3'd0;
	localparam logic [2:0] KIND_STOP = 3'd1;
	localparam logic [2:0] KIND_WRITE = 3'd2;
	localparam logic [2:0] KIND_READ = 3'd3;
	localparam logic [2:0] KIND_ACK = 3'd4;
	localparam logic [2:0] KIND_NACK = 3'd5;
	localparam logic [2:0] KIND_WAIT = 3'd6;

	localparam logic [2:0] PH_0 = 3'd0;
	localparam logic [2:0] PH_1 = 3'd1;
	localparam logic [2:0] PH_2 = 3'd2;
	localparam logic [2:0] PH_3 = 3'd3;
	localparam logic [2:0] PH_5 = 3'd5;

	typedef struct packed {
		logic                 cmd_valid;
		logic [2:0]           kind;
		logic [BYTE_BITS-1:0] write_data;
		logic                 sda_in;
	} item_t;

	typedef struct packed {
		logic                 running;
		logic [2:0]           cmd;
		logic [2:0]           phase;
		logic [2:0]           bit_idx;
		logic [HP_W-1:0]      tick;
		logic [BYTE_BITS-1:0] shift;
		logic [TMO_W-1:0]     tmo;
		logic                 scl;
		logic                 sda;
		logic                 drv;
		logic                 ack_fail;
		logic [BYTE_BITS-1:0] rdata;
	} seq_state_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_level;
		logic                 sda_enable;
		logic                 busy_res;
		logic                 done_res;
		logic [BYTE_BITS-1:0] read_data;
		logic                 no_ack;
	} result_t;

	localparam seq_state_t STATE_RST = '{
		running: 1'b0, cmd: KIND_START, phase: PH_0, bit_idx: 3'd0, tick: '0,
		shift: '0, tmo: '0, scl: 1'b1, sda: 1'b1, drv: 1'b1, ack_fail: 1'b0,
		rdata: '0
	};

	// stop sequence: SCL low with SDA low, SCL high, then SDA high
	function automatic seq_state_t stop_phase(seq_state_t s, logic [2:0] sp);
		seq_state_t r;
		r = s;
		if (sp == PH_0) begin
			r.scl = 1'b0;
			r.sda = 1'b0;
			r.drv = 1'b1;
		end else if (sp == PH_1) begin
			r.scl = 1'b1;
		end else begin
			r.sda = 1'b1;
		end
		return r;
	endfunction

	// line levels on entry to phase p of the active command
	function automatic seq_state_t enter_phase(seq_state_t s, logic [2:0] p);
		seq_state_t r;
		logic [BYTE_BITS-1:0] sh;
		r = s;
		r.phase = p;
		r.tick = HP_W'(1);
		sh = {s.shift[BYTE_BITS-2:0], 1'b0};
		unique case (s.cmd)
			KIND_START: begin
				if (p == PH_0) begin
					r.scl = 1'b1;
					r.sda = 1'b1;
					r.drv = 1'b1;
				end else if (p == PH_1) begin
					r.sda = 1'b0;
				end else begin
					r.scl = 1'b0;
				end
			end
			KIND_STOP: r = stop_phase(r, p);
			KIND_ACK, KIND_NACK: begin
				if (p == PH_0) begin
					r.scl = 1'b0;
					r.drv = 1'b1;
					r.sda = (s.cmd == KIND_NACK);
				end else if (p == PH_1) begin
					r.scl = 1'b1;
				end else begin
					r.scl = 1'b0;
					r.sda = 1'b1;
				end
			end
			KIND_WRITE: begin
				if (p == PH_0) begin
					r.scl = 1'b0;
					r.drv = 1'b1;
					r.sda = s.shift[BYTE_BITS-1];
				end else if (p == PH_1) begin
					r.scl = 1'b1;
				end else begin
					r.scl = 1'b0;
					if (s.bit_idx != 3'(BYTE_BITS - 1)) begin
						r.shift = sh;
						r.sda = sh[BYTE_BITS-1];
					end
				end
			end
			KIND_READ: begin
				if (p == PH_0) begin
					r.scl = 1'b1;
					r.drv = 1'b0;
				end else begin
					r.scl = 1'b0;
				end
			end
			default: begin
				if (s.cmd == KIND_WAIT && p >= PH_3) begin
					r = stop_phase(r, p - PH_3);
				end else if (p == PH_0) begin
					r.scl = 1'b1;
					r.drv = 1'b0;
				end else if (p == PH_1) begin
					r.tmo = '0;
				end else begin
					r.scl = 1'b0;
				end
			end
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/i2cms_step.sv
// Per-tick next-state and result logic of the I2C master byte sequencer.
`timescale 1ns / 1ps

module i2cms_step (
	input  i2cms_pkg::seq_state_t                cur,
	input  i2cms_pkg::item_t                     item,
	input  logic [i2cms_pkg::HP_W-1:0]           half_period,
	input  logic [i2cms_pkg::TMO_W-1:0]          ack_timeout,
	output i2cms_pkg::seq_state_t                nxt,
	output i2cms_pkg::result_t                   res
);

	logic [i2cms_pkg::HP_W-1:0] hp;
	logic                       done;
	logic [2:0]                 bit_inc;
	i2cms_pkg::seq_state_t      st;

	assign hp = (half_period == '0) ? i2cms_pkg::HP_W'(1) : half_period;
	assign bit_inc = cur.bit_idx + 3'd1;

	always_comb begin
		nxt = cur;
		st = cur;
		done = 1'b0;
		if (cur.running) begin
			if (cur.cmd == i2cms_pkg::KIND_WAIT && cur.phase == i2cms_pkg::PH_1) begin
				if (!item.sda_in) begin
					nxt = i2cms_pkg::enter_phase(cur, i2cms_pkg::PH_2);
				end else if (cur.tmo >= ack_timeout) begin
					nxt = i2cms_pkg::enter_phase(cur, i2cms_pkg::PH_3);
				end else begin
					nxt.tmo = cur.tmo + 1'b1;
				end
			end else if (cur.tick < hp) begin
				nxt.tick = cur.tick + 1'b1;
			end else begin
				unique case (cur.cmd)
					i2cms_pkg::KIND_WRITE: begin
						if (cur.phase == i2cms_pkg::PH_0) begin
							nxt = i2cms_pkg::enter_phase(cur, i2cms_pkg::PH_1);
						end else if (cur.phase == i2cms_pkg::PH_1) begin
							nxt = i2cms_pkg::enter_phase(cur, i2cms_pkg::PH_2);
						end else begin
							st.bit_idx = bit_inc;
							if (bit_inc == 3'd0) begin
								nxt = st;
								done = 1'b1;
							end else begin
								nxt = i2cms_pkg::enter_phase(st, i2cms_pkg::PH_1);
							end
						end
					end
					i2cms_pkg::KIND_READ: begin
						if (cur.phase == i2cms_pkg::PH_0) begin
							st.shift = {cur.shift[i2cms_pkg::BYTE_BITS-2:0], item.sda_in};
							nxt = i2cms_pkg::enter_phase(st, i2cms_pkg::PH_1);
						end else begin
							st.bit_idx = bit_inc;
							if (bit_inc == 3'd0) begin
								st.rdata = cur.shift;
								nxt = st;
								done = 1'b1;
							end else begin
								nxt = i2cms_pkg::enter_phase(st, i2cms_pkg::PH_0);
							end
						end
					end
					i2cms_pkg::KIND_WAIT: begin
						if (cur.phase == i2cms_pkg::PH_2) begin
							nxt.ack_fail = 1'b0;
							done = 1'b1;
						end else if (cur.phase == i2cms_pkg::PH_5) begin
							nxt.ack_fail = 1'b1;
							done = 1'b1;
						end else begin
							nxt = i2cms_pkg::enter_phase(cur, cur.phase + 3'd1);
						end
					end
					default: begin
						if (cur.phase >= i2cms_pkg::PH_2) begin
							done = 1'b1;
						end else begin
							nxt = i2cms_pkg::enter_phase(cur, cur.phase + 3'd1);
						end
					end
				endcase
				if (done) begin
					nxt.running = 1'b0;
					nxt.phase = i2cms_pkg::PH_0;
					nxt.tick = '0;
				end
			end
		end else if (item.cmd_valid && item.kind <= i2cms_pkg::KIND_WAIT) begin
			st.cmd = item.kind;
			st.bit_idx = 3'd0;
			st.running = 1'b1;
			if (item.kind == i2cms_pkg::KIND_WRITE) begin
				st.shift = item.write_data;
			end else if (item.kind == i2cms_pkg::KIND_READ) begin
				st.shift = '0;
			end
			nxt = i2cms_pkg::enter_phase(st, i2cms_pkg::PH_0);
		end
	end

	always_comb begin
		res.scl_level = nxt.scl;
		res.sda_level = nxt.drv ? nxt.sda : 1'b1;
		res.sda_enable = nxt.drv;
		res.busy_res = nxt.running;
		res.done_res = done;
		res.read_data = nxt.rdata;
		res.no_ack = nxt.ack_fail;
	end

endmodule

FILE: rtl/i2c_master_byte_sequencer_top.sv
// Top level of the I2C master byte sequencer: item register, state, result register.
`timescale 1ns / 1ps

// Each input item is one timer tick; one item is accepted per clock and gives one
// result item. An accepted item sits in the input register until the result register
// can take it; then the sequencer state and the result register update together, and
// its result shows from the result register. The input register takes a new item while
// the previous result waits; throughput drops only while out_ready is held low.
// Registers: index 0 half_period (ticks per SCL half phase, reset 5), index 1
// ack_timeout (high SDA ticks tolerated in wait-ack, reset 250). Write them only
// while the block is idle.

module i2c_master_byte_sequencer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [0:0]                            cfg_index,
	input  logic [i2cms_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd_valid,
	input  logic [2:0]                            kind,
	input  logic [i2cms_pkg::BYTE_BITS-1:0]       write_data,
	input  logic                                  sda_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  scl_level,
	output logic                                  sda_level,
	output logic                                  sda_enable,
	output logic                                  busy_res,
	output logic                                  done_res,
	output logic [i2cms_pkg::BYTE_BITS-1:0]       read_data,
	output logic                                  no_ack
);

	logic [i2cms_pkg::HP_W-1:0]  half_period_q;
	logic [i2cms_pkg::TMO_W-1:0] ack_timeout_q;
	i2cms_pkg::item_t            item_s1;
	logic                        valid_s1;
	i2cms_pkg::seq_state_t       state_q;
	i2cms_pkg::seq_state_t       state_nxt;
	i2cms_pkg::result_t          res_nxt;
	i2cms_pkg::result_t          res_q;
	logic                        out_valid_q;
	logic                        adv;
	logic                        take;

	assign adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cms_pkg::HALF_PERIOD_RST;
			ack_timeout_q <= i2cms_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cms_pkg::REG_HALF_PERIOD: half_period_q <= cfg_data;
				i2cms_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[i2cms_pkg::TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{cmd_valid: cmd_valid, kind: kind, write_data: write_data,
				sda_in: sda_in};
		end
	end

	i2cms_step u_step (
		.cur         (state_q),
		.item        (item_s1),
		.half_period (half_period_q),
		.ack_timeout (ack_timeout_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cms_pkg::STATE_RST;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = res_q.scl_level;
	assign sda_level = res_q.sda_level;
	assign sda_enable = res_q.sda_enable;
	assign busy_res = res_q.busy_res;
	assign done_res = res_q.done_res;
	assign read_data = res_q.read_data;
	assign no_ack = res_q.no_ack;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("completed item still reports busy");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("sequencer state moved without an item");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.running |-> state_q.phase == i2cms_pkg::PH_0 && state_q.tick == '0)
		else $error("idle sequencer holds phase or tick count");

endmodule

FILE: tb/i2c_master_byte_sequencer_top_test.sv
// Self-checking testbench for the I2C master byte sequencer top level.
`timescale 1ns / 1ps

class i2c_line_scoreboard;
	logic [i2cms_pkg::HP_W-1:0] half_period;
	logic [i2cms_pkg::TMO_W-1:0] ack_timeout;
	bit busy;
	logic [2:0] cmd;
	int phase;
	int bit_idx;
	int tick;
	logic [i2cms_pkg::BYTE_BITS-1:0] shift;
	int tmo;
	bit scl, sda, drv, ack_fail;
	logic [i2cms_pkg::BYTE_BITS-1:0] rdata;
	i2cms_pkg::result_t line_expect[$];
	int errors;

	function new();
		half_period = i2cms_pkg::HALF_PERIOD_RST;
		ack_timeout = i2cms_pkg::ACK_TIMEOUT_RST;
		busy = 0;
		cmd = i2cms_pkg::KIND_START;
		phase = 0;
		bit_idx = 0;
		tick = 0;
		shift = '0;
		tmo = 0;
		scl = 1;
		sda = 1;
		drv = 1;
		ack_fail = 0;
		rdata = '0;
		errors = 0;
	endfunction

	function void write_reg(logic [0:0] idx, logic [i2cms_pkg::CFG_W-1:0] val);
		if (idx == i2cms_pkg::REG_HALF_PERIOD) half_period = val;
		else ack_timeout = val[i2cms_pkg::TMO_W-1:0];
	endfunction

	// SCL low with SDA low, SCL high, SDA high
	function void stop_step(int s);
		if (s == 0) begin
			scl = 0;
			sda = 0;
			drv = 1;
		end else if (s == 1) begin
			scl = 1;
		end else begin
			sda = 1;
		end
	endfunction

	function void open_phase(int p);
		phase = p;
		tick = 1;
		unique case (cmd)
			i2cms_pkg::KIND_START: begin
				if (p == 0) begin
					scl = 1;
					sda = 1;
					drv = 1;
				end else if (p == 1) begin
					sda = 0;
				end else begin
					scl = 0;
				end
			end
			i2cms_pkg::KIND_STOP: stop_step(p);
			i2cms_pkg::KIND_ACK, i2cms_pkg::KIND_NACK: begin
				if (p == 0) begin
					scl = 0;
					drv = 1;
					sda = (cmd == i2cms_pkg::KIND_NACK);
				end else if (p == 1) begin
					scl = 1;
				end else begin
					scl = 0;
					sda = 1;
				end
			end
			i2cms_pkg::KIND_WRITE: begin
				if (p == 0) begin
					scl = 0;
					drv = 1;
					sda = shift[i2cms_pkg::BYTE_BITS-1];
				end else if (p == 1) begin
					scl = 1;
				end else begin
					scl = 0;
					if (bit_idx + 1 < i2cms_pkg::BYTE_BITS) begin
						shift = shift << 1;
						sda = shift[i2cms_pkg::BYTE_BITS-1];
					end
				end
			end
			i2cms_pkg::KIND_READ: begin
				if (p == 0) begin
					scl = 1;
					drv = 0;
				end else begin
					scl = 0;
				end
			end
			default: begin
				if (p >= 3) begin
					stop_step(p - 3);
				end else if (p == 0) begin
					scl = 1;
					drv = 0;
				end else if (p == 1) begin
					tmo = 0;
				end else begin
					scl = 0;
				end
			end
		endcase
	endfunction

	// end of a timed phase; 1 when the command completes
	function bit close_phase(bit s);
		unique case (cmd)
			i2cms_pkg::KIND_WRITE: begin
				if (phase < 2) begin
					open_phase(phase + 1);
					return 0;
				end
				bit_idx = (bit_idx + 1) % i2cms_pkg::BYTE_BITS;
				if (bit_idx == 0) return 1;
				open_phase(1);
				return 0;
			end
			i2cms_pkg::KIND_READ: begin
				if (phase == 0) begin
					shift = {shift[i2cms_pkg::BYTE_BITS-2:0], s};
					open_phase(1);
					return 0;
				end
				bit_idx = (bit_idx + 1) % i2cms_pkg::BYTE_BITS;
				if (bit_idx == 0) begin
					rdata = shift;
					return 1;
				end
				open_phase(0);
				return 0;
			end
			i2cms_pkg::KIND_WAIT: begin
				if (phase == 2 || phase == 5) begin
					ack_fail = (phase == 5);
					return 1;
				end
				open_phase(phase + 1);
				return 0;
			end
			default: begin
				if (phase >= 2) return 1;
				open_phase(phase + 1);
				return 0;
			end
		endcase
		return 0;
	endfunction

	function void note_item(logic v, logic [2:0] k, logic [i2cms_pkg::BYTE_BITS-1:0] d,
			logic s);
		int hp;
		bit fin;
		i2cms_pkg::result_t r;
		hp = (half_period == 0) ? 1 : half_period;
		fin = 0;
		if (busy) begin
			if (cmd == i2cms_pkg::KIND_WAIT && phase == 1) begin
				if (!s) open_phase(2);
				else if (tmo >= ack_timeout) open_phase(3);
				else tmo++;
			end else if (tick < hp) begin
				tick++;
			end else if (close_phase(s)) begin
				busy = 0;
				phase = 0;
				tick = 0;
				fin = 1;
			end
		end else if (v && k <= i2cms_pkg::KIND_WAIT) begin
			cmd = k;
			bit_idx = 0;
			if (k == i2cms_pkg::KIND_WRITE) shift = d;
			else if (k == i2cms_pkg::KIND_READ) shift = '0;
			busy = 1;
			open_phase(0);
		end
		r.scl_level = scl;
		r.sda_level = drv ? sda : 1'b1;
		r.sda_enable = drv;
		r.busy_res = busy;
		r.done_res = fin;
		r.read_data = rdata;
		r.no_ack = ack_fail;
		line_expect.push_back(r);
	endfunction

	function void field_check(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(i2cms_pkg::result_t got);
		i2cms_pkg::result_t want;
		if (line_expect.size() == 0) begin
			$error("result item with no expectation pending");
			errors++;
			return;
		end
		want = line_expect.pop_front();
		field_check("scl_level", want.scl_level, got.scl_level);
		field_check("sda_level", want.sda_level, got.sda_level);
		field_check("sda_enable", want.sda_enable, got.sda_enable);
		field_check("busy_res", want.busy_res, got.busy_res);
		field_check("done_res", want.done_res, got.done_res);
		field_check("read_data", want.read_data, got.read_data);
		field_check("no_ack", want.no_ack, got.no_ack);
	endfunction
endclass

module i2c_master_byte_sequencer_top_test;
	localparam logic [2:0] KIND_NONE = 3'd7;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = i2cms_pkg::REG_HALF_PERIOD;
	logic [i2cms_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd_valid = 1'b0;
	logic [2:0] kind = i2cms_pkg::KIND_START;
	logic [i2cms_pkg::BYTE_BITS-1:0] write_data = '0;
	logic sda_in = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic scl_level, sda_level, sda_enable, busy_res, done_res, no_ack;
	logic [i2cms_pkg::BYTE_BITS-1:0] read_data;

	int gap_pct = 0;
	int stall_pct = 0;
	int ticks_sent = 0;
	i2c_line_scoreboard sb = new();

	i2c_master_byte_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd_valid(cmd_valid),
		.kind(kind),
		.write_data(write_data),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl_level(scl_level),
		.sda_level(sda_level),
		.sda_enable(sda_enable),
		.busy_res(busy_res),
		.done_res(done_res),
		.read_data(read_data),
		.no_ack(no_ack)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(i2cms_pkg::result_t'{scl_level, sda_level, sda_enable,
				busy_res, done_res, read_data, no_ack});
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic put_tick(input logic v, input logic [2:0] k, input logic [7:0] d,
			input logic s);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd_valid <= v;
		kind <= k;
		write_data <= d;
		sda_in <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(v, k, d, s);
		ticks_sent++;
	endtask

	// issue one command, then tick with noise until it finishes
	task automatic run_command(input logic [2:0] k, input logic [7:0] d, input int ack_after);
		logic s;
		put_tick(1'b1, k, d, 1'($urandom));
		while (sb.busy) begin
			if (sb.cmd == i2cms_pkg::KIND_WAIT && sb.phase == 1) s = (sb.tmo < ack_after);
			else s = 1'($urandom);
			put_tick($urandom_range(0, 3) == 0, 3'($urandom), 8'($urandom), s);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.line_expect.size() != 0) @(posedge clk);
	endtask

	task automatic program_regs(input logic [i2cms_pkg::HP_W-1:0] hp,
			input logic [i2cms_pkg::TMO_W-1:0] tmo);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= i2cms_pkg::REG_HALF_PERIOD;
		cfg_data <= hp;
		@(posedge clk);
		sb.write_reg(i2cms_pkg::REG_HALF_PERIOD, hp);
		cfg_index <= i2cms_pkg::REG_ACK_TIMEOUT;
		cfg_data <= i2cms_pkg::CFG_W'(tmo);
		@(posedge clk);
		sb.write_reg(i2cms_pkg::REG_ACK_TIMEOUT, i2cms_pkg::CFG_W'(tmo));
		cfg_we <= 1'b0;
	endtask

	task automatic random_command();
		int r;
		logic [2:0] k;
		if ($urandom_range(0, 3) == 0)
			put_tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom));
		r = $urandom_range(0, 15);
		k = (r == 15) ? KIND_NONE : 3'(r % 7);
		run_command(k, 8'($urandom), ($urandom_range(0, 3) == 0) ?
			int'(sb.ack_timeout) + 1 : $urandom_range(0, sb.ack_timeout));
	endtask

	task automatic run_phase(input int gap, input int stall, input int n,
			input logic [i2cms_pkg::HP_W-1:0] hp, input logic [i2cms_pkg::TMO_W-1:0] tmo);
		int stop_at;
		program_regs(hp, tmo);
		gap_pct = gap;
		stall_pct = stall;
		stop_at = ticks_sent + n;
		while (ticks_sent < stop_at) random_command();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		program_regs(16'd1, i2cms_pkg::ACK_TIMEOUT_RST);
		run_command(i2cms_pkg::KIND_START, 8'h00, 0);
		run_command(i2cms_pkg::KIND_WRITE, 8'h00, 0);
		run_command(i2cms_pkg::KIND_WAIT, 8'h00, 0);
		run_command(i2cms_pkg::KIND_WRITE, 8'hFF, 0);
		run_command(i2cms_pkg::KIND_WAIT, 8'h00, 3);
		run_command(i2cms_pkg::KIND_START, 8'h00, 0);	// repeated start
		run_command(i2cms_pkg::KIND_WRITE, 8'hA5, 0);
		run_command(i2cms_pkg::KIND_READ, 8'h00, 0);
		run_command(i2cms_pkg::KIND_ACK, 8'h00, 0);
		run_command(i2cms_pkg::KIND_READ, 8'h00, 0);
		run_command(i2cms_pkg::KIND_NACK, 8'h00, 0);
		run_command(KIND_NONE, 8'h00, 0);
		run_command(i2cms_pkg::KIND_STOP, 8'h00, 0);

		// zero half period acts as one tick; zero timeout fails on first high poll
		program_regs(16'd0, 8'd0);
		run_command(i2cms_pkg::KIND_START, 8'h00, 0);
		run_command(i2cms_pkg::KIND_WAIT, 8'h00, 1);
		run_command(i2cms_pkg::KIND_READ, 8'h00, 0);

		program_regs(16'd3, 8'd255);
		run_command(i2cms_pkg::KIND_WAIT, 8'h00, 300);
		run_command(i2cms_pkg::KIND_WAIT, 8'h00, 255);

		program_regs(16'd20, 8'd1);
		run_command(i2cms_pkg::KIND_START, 8'h00, 0);

		run_phase(0, 0, 250, 16'd2, 8'd6);
		run_phase(57, 0, 250, 16'd1, 8'd12);
		run_phase(0, 57, 250, 16'd3, 8'd1);
		run_phase(18, 18, 250, 16'd4, 8'd30);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("end of test: mismatches");
		$finish;
	end
endmodule
